>>> rtl/sch_pkg.sv
// Shared types, widths, register map and arithmetic helpers for the segment/circle hit test.
package sch_pkg;

    // Coordinate format: Q12.4 two's complement
    localparam int CW   = 16;
    // Difference of two coordinates
    localparam int DFW  = CW + 1;
    // Product of two differences
    localparam int PRW  = 2 * DFW;
    // Sum of two products, signed
    localparam int SMW  = PRW + 1;
    // Magnitude of such a sum
    localparam int MGW  = PRW;
    // Half of a magnitude, for split multiplies
    localparam int HW   = MGW / 2;
    // Radius and radius squared
    localparam int RW   = CW - 1;
    localparam int R2W  = 2 * RW;
    // Squared cross product and r^2 * L2
    localparam int SQW  = 2 * MGW;
    // |v| * |dot|
    localparam int NMW  = DFW + MGW;
    // Dividend 2*|num| + L2 and divisor 2*L2
    localparam int NNW  = NMW + 2;
    localparam int DDW  = MGW + 1;
    // Quotient bits kept; anything larger saturates the foot anyway
    localparam int QW   = CW + 1;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int IDX_W  = 2;
    localparam logic [IDX_W-1:0] REG_CENTRE_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_CENTRE_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_RADIUS   = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } seg_t;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] foot_x;
        logic signed [CW-1:0] foot_y;
        logic                 zero_length;
    } res_t;

    typedef struct packed {
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic [RW-1:0]        radius;
    } cfg_t;

    // Flags and start point that ride alongside the divider
    typedef struct packed {
        logic                 hit;
        logic                 zl;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
    } side_t;

    typedef struct packed {
        logic [NNW-1:0] num_x;
        logic [NNW-1:0] num_y;
        logic [DDW-1:0] den;
        side_t          side;
    } front_t;

    // Signed difference times difference
    function automatic logic signed [PRW-1:0] smul(input logic signed [DFW-1:0] a,
                                                   input logic signed [DFW-1:0] b);
        logic signed [PRW-1:0] ea;
        logic signed [PRW-1:0] eb;
        ea = PRW'(a);
        eb = PRW'(b);
        return ea * eb;
    endfunction

    // Unsigned half by half
    function automatic logic [2*HW-1:0] umul(input logic [HW-1:0] a,
                                             input logic [HW-1:0] b);
        logic [2*HW-1:0] ea;
        logic [2*HW-1:0] eb;
        ea = (2*HW)'(a);
        eb = (2*HW)'(b);
        return ea * eb;
    endfunction

    // Radius squared by a half of L2
    function automatic logic [R2W+HW-1:0] rmul(input logic [R2W-1:0] a,
                                               input logic [HW-1:0] b);
        logic [R2W+HW-1:0] ea;
        logic [R2W+HW-1:0] eb;
        ea = (R2W+HW)'(a);
        eb = (R2W+HW)'(b);
        return ea * eb;
    endfunction

    // Magnitude of a sum of products; never reaches 2^MGW
    function automatic logic [MGW-1:0] absm(input logic signed [SMW-1:0] x);
        logic signed [SMW-1:0] n;
        n = x[SMW-1] ? -x : x;
        return n[MGW-1:0];
    endfunction

endpackage

>>> rtl/sch_front.sv
// Geometry pipeline: differences, products, squared tests and dividend/divisor build.
module sch_front
    import sch_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  seg_t   seg,
    input  cfg_t   cfg,
    output logic   out_valid,
    input  logic   out_ready,
    output front_t out
);

    localparam int NST = 7;

    logic [NST:1]   v_reg;
    logic [NST+1:1] en;

    // Stage 1: differences
    logic signed [DFW-1:0] s1_vx_reg, s1_vy_reg, s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [CW-1:0]  s1_sx_reg, s1_sy_reg;
    logic                  s1_zl_reg;
    // Stage 2: products
    logic signed [PRW-1:0] s2_vvx_reg, s2_vvy_reg, s2_cra_reg, s2_crb_reg;
    logic signed [PRW-1:0] s2_dax_reg, s2_day_reg, s2_dbx_reg, s2_dby_reg;
    logic signed [PRW-1:0] s2_aax_reg, s2_aay_reg, s2_bbx_reg, s2_bby_reg, s2_r2_reg;
    logic signed [DFW-1:0] s2_vx_reg, s2_vy_reg;
    logic signed [CW-1:0]  s2_sx_reg, s2_sy_reg;
    logic                  s2_zl_reg;
    // Stage 3: sums
    logic signed [SMW-1:0] s3_l2_reg, s3_cr_reg, s3_dva_reg, s3_dvb_reg, s3_a2_reg, s3_b2_reg;
    logic [DFW-1:0]        s3_vxm_reg, s3_vym_reg;
    logic                  s3_vxn_reg, s3_vyn_reg;
    logic [R2W-1:0]        s3_r2_reg;
    logic signed [CW-1:0]  s3_sx_reg, s3_sy_reg;
    logic                  s3_zl_reg;
    // Stage 4: magnitudes and flags
    logic [MGW-1:0]        s4_crm_reg, s4_dvm_reg, s4_l2_reg;
    logic [DFW-1:0]        s4_vxm_reg, s4_vym_reg;
    logic [R2W-1:0]        s4_r2_reg;
    logic                  s4_between_reg, s4_inside_reg, s4_negx_reg, s4_negy_reg;
    logic signed [CW-1:0]  s4_sx_reg, s4_sy_reg;
    logic                  s4_zl_reg;
    // Stage 5: partial products
    logic [2*HW-1:0]       s5_hh_reg, s5_hl_reg, s5_ll_reg;
    logic [2*HW-1:0]       s5_nxh_reg, s5_nxl_reg, s5_nyh_reg, s5_nyl_reg;
    logic [R2W+HW-1:0]     s5_rlh_reg, s5_rll_reg;
    logic [MGW-1:0]        s5_l2_reg;
    logic                  s5_bi_reg;
    side_t                 s5_side_reg;
    // Stage 6: recombined wide values
    logic [SQW-1:0]        s6_cr2_reg, s6_rl2_reg;
    logic [NMW-1:0]        s6_nx_reg, s6_ny_reg;
    logic [MGW-1:0]        s6_l2_reg;
    logic                  s6_bi_reg;
    side_t                 s6_side_reg;
    // Stage 7: near test, dividend and divisor
    front_t                s7_out_reg;

    // Stall chain: a stage moves when it is empty or the next one moves
    assign en[NST+1] = out_ready;
    genvar k;
    generate
        for (k = 1; k <= NST; k++) begin : g_en
            assign en[k] = ~v_reg[k] | en[k+1];
        end
    endgenerate

    assign in_ready  = en[1];
    assign out_valid = v_reg[NST];
    assign out       = s7_out_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int i = 2; i <= NST; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Stage 1
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_vx_reg <= DFW'(seg.end_x) - DFW'(seg.start_x);
            s1_vy_reg <= DFW'(seg.end_y) - DFW'(seg.start_y);
            s1_ax_reg <= DFW'(cfg.centre_x) - DFW'(seg.start_x);
            s1_ay_reg <= DFW'(cfg.centre_y) - DFW'(seg.start_y);
            s1_bx_reg <= DFW'(cfg.centre_x) - DFW'(seg.end_x);
            s1_by_reg <= DFW'(cfg.centre_y) - DFW'(seg.end_y);
            s1_sx_reg <= seg.start_x;
            s1_sy_reg <= seg.start_y;
            s1_zl_reg <= (seg.start_x == seg.end_x) && (seg.start_y == seg.end_y);
        end
    end

    // Stage 2
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_vvx_reg <= smul(s1_vx_reg, s1_vx_reg);
            s2_vvy_reg <= smul(s1_vy_reg, s1_vy_reg);
            s2_cra_reg <= smul(s1_vx_reg, s1_ay_reg);
            s2_crb_reg <= smul(s1_vy_reg, s1_ax_reg);
            s2_dax_reg <= smul(s1_vx_reg, s1_ax_reg);
            s2_day_reg <= smul(s1_vy_reg, s1_ay_reg);
            s2_dbx_reg <= smul(s1_vx_reg, s1_bx_reg);
            s2_dby_reg <= smul(s1_vy_reg, s1_by_reg);
            s2_aax_reg <= smul(s1_ax_reg, s1_ax_reg);
            s2_aay_reg <= smul(s1_ay_reg, s1_ay_reg);
            s2_bbx_reg <= smul(s1_bx_reg, s1_bx_reg);
            s2_bby_reg <= smul(s1_by_reg, s1_by_reg);
            s2_r2_reg  <= smul(DFW'(cfg.radius), DFW'(cfg.radius));
            s2_vx_reg  <= s1_vx_reg;
            s2_vy_reg  <= s1_vy_reg;
            s2_sx_reg  <= s1_sx_reg;
            s2_sy_reg  <= s1_sy_reg;
            s2_zl_reg  <= s1_zl_reg;
        end
    end

    // Stage 3
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_l2_reg  <= SMW'(s2_vvx_reg) + SMW'(s2_vvy_reg);
            s3_cr_reg  <= SMW'(s2_cra_reg) - SMW'(s2_crb_reg);
            s3_dva_reg <= SMW'(s2_dax_reg) + SMW'(s2_day_reg);
            s3_dvb_reg <= SMW'(s2_dbx_reg) + SMW'(s2_dby_reg);
            s3_a2_reg  <= SMW'(s2_aax_reg) + SMW'(s2_aay_reg);
            s3_b2_reg  <= SMW'(s2_bbx_reg) + SMW'(s2_bby_reg);
            s3_vxm_reg <= s2_vx_reg[DFW-1] ? DFW'(-s2_vx_reg) : DFW'(s2_vx_reg);
            s3_vym_reg <= s2_vy_reg[DFW-1] ? DFW'(-s2_vy_reg) : DFW'(s2_vy_reg);
            s3_vxn_reg <= s2_vx_reg[DFW-1];
            s3_vyn_reg <= s2_vy_reg[DFW-1];
            s3_r2_reg  <= s2_r2_reg[R2W-1:0];
            s3_sx_reg  <= s2_sx_reg;
            s3_sy_reg  <= s2_sy_reg;
            s3_zl_reg  <= s2_zl_reg;
        end
    end

    // Stage 4
    logic signed [SMW-1:0] r2_ext;
    assign r2_ext = SMW'(s3_r2_reg);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_crm_reg     <= absm(s3_cr_reg);
            s4_dvm_reg     <= absm(s3_dva_reg);
            s4_l2_reg      <= s3_l2_reg[MGW-1:0];
            s4_vxm_reg     <= s3_vxm_reg;
            s4_vym_reg     <= s3_vym_reg;
            s4_r2_reg      <= s3_r2_reg;
            s4_between_reg <= (s3_dva_reg == '0) || (s3_dvb_reg == '0)
                              || (s3_dva_reg[SMW-1] != s3_dvb_reg[SMW-1]);
            s4_inside_reg  <= (s3_a2_reg < r2_ext) || (s3_b2_reg < r2_ext);
            s4_negx_reg    <= s3_vxn_reg ^ s3_dva_reg[SMW-1];
            s4_negy_reg    <= s3_vyn_reg ^ s3_dva_reg[SMW-1];
            s4_sx_reg      <= s3_sx_reg;
            s4_sy_reg      <= s3_sy_reg;
            s4_zl_reg      <= s3_zl_reg;
        end
    end

    // Stage 5: 17-bit halves keep every multiplier narrow
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_hh_reg  <= umul(s4_crm_reg[MGW-1:HW], s4_crm_reg[MGW-1:HW]);
            s5_hl_reg  <= umul(s4_crm_reg[MGW-1:HW], s4_crm_reg[HW-1:0]);
            s5_ll_reg  <= umul(s4_crm_reg[HW-1:0], s4_crm_reg[HW-1:0]);
            s5_rlh_reg <= rmul(s4_r2_reg, s4_l2_reg[MGW-1:HW]);
            s5_rll_reg <= rmul(s4_r2_reg, s4_l2_reg[HW-1:0]);
            s5_nxh_reg <= umul(HW'(s4_vxm_reg), s4_dvm_reg[MGW-1:HW]);
            s5_nxl_reg <= umul(HW'(s4_vxm_reg), s4_dvm_reg[HW-1:0]);
            s5_nyh_reg <= umul(HW'(s4_vym_reg), s4_dvm_reg[MGW-1:HW]);
            s5_nyl_reg <= umul(HW'(s4_vym_reg), s4_dvm_reg[HW-1:0]);
            s5_l2_reg  <= s4_l2_reg;
            s5_bi_reg  <= s4_between_reg | s4_inside_reg;
            s5_side_reg.hit   <= 1'b0;
            s5_side_reg.zl    <= s4_zl_reg;
            s5_side_reg.neg_x <= s4_negx_reg;
            s5_side_reg.neg_y <= s4_negy_reg;
            s5_side_reg.sx    <= s4_sx_reg;
            s5_side_reg.sy    <= s4_sy_reg;
        end
    end

    // Stage 6
    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_cr2_reg  <= (SQW'(s5_hh_reg) << (2*HW)) + (SQW'(s5_hl_reg) << (HW+1))
                           + SQW'(s5_ll_reg);
            s6_rl2_reg  <= (SQW'(s5_rlh_reg) << HW) + SQW'(s5_rll_reg);
            s6_nx_reg   <= (NMW'(s5_nxh_reg) << HW) + NMW'(s5_nxl_reg);
            s6_ny_reg   <= (NMW'(s5_nyh_reg) << HW) + NMW'(s5_nyl_reg);
            s6_l2_reg   <= s5_l2_reg;
            s6_bi_reg   <= s5_bi_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // Stage 7: rounding dividend is 2*|num| + L2 over 2*L2
    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_out_reg.num_x      <= (NNW'(s6_nx_reg) << 1) + NNW'(s6_l2_reg);
            s7_out_reg.num_y      <= (NNW'(s6_ny_reg) << 1) + NNW'(s6_l2_reg);
            s7_out_reg.den        <= DDW'(s6_l2_reg) << 1;
            s7_out_reg.side.hit   <= ~s6_side_reg.zl & s6_bi_reg & (s6_cr2_reg <= s6_rl2_reg);
            s7_out_reg.side.zl    <= s6_side_reg.zl;
            s7_out_reg.side.neg_x <= s6_side_reg.neg_x;
            s7_out_reg.side.neg_y <= s6_side_reg.neg_y;
            s7_out_reg.side.sx    <= s6_side_reg.sx;
            s7_out_reg.side.sy    <= s6_side_reg.sy;
        end
    end

endmodule

>>> rtl/sch_div.sv
// Pipelined restoring divider, two lanes, one divisor, one quotient bit per later stage.
module sch_div
    import sch_pkg::*;
#(
    parameter int NW = 53,
    parameter int DW = 35,
    parameter int QW_P = 17,
    parameter int SW = 36
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0][NW-1:0]    num,
    input  logic [DW-1:0]         den,
    input  logic [SW-1:0]         side_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0][QW_P-1:0]  quo,
    output logic [1:0]            ovf,
    output logic [SW-1:0]         side_out
);

    localparam int RMW = NW - QW_P;

    logic [QW_P:0]   v_reg;
    logic [QW_P+1:0] en;

    logic [1:0][RMW-1:0]  rem_reg  [QW_P+1];
    logic [1:0][QW_P-1:0] lo_reg   [QW_P+1];
    logic [1:0][QW_P-1:0] q_reg    [QW_P+1];
    logic [1:0]           ovf_reg  [QW_P+1];
    logic [DW-1:0]        den_reg  [QW_P+1];
    logic [SW-1:0]        side_reg [QW_P+1];

    assign en[QW_P+1] = out_ready;
    genvar j, l;
    generate
        for (j = 0; j <= QW_P; j++) begin : g_en
            assign en[j] = ~v_reg[j] | en[j+1];
        end
    endgenerate

    assign in_ready  = en[0];
    assign out_valid = v_reg[QW_P];
    assign quo       = q_reg[QW_P];
    assign ovf       = ovf_reg[QW_P];
    assign side_out  = side_reg[QW_P];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i <= QW_P; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // First stage: quotient too large for the kept bits
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 2; i++)
            begin
                rem_reg[0][i] <= num[i][NW-1:QW_P];
                lo_reg[0][i]  <= num[i][QW_P-1:0];
                ovf_reg[0][i] <= num[i][NW-1:QW_P] >= RMW'(den);
            end
            q_reg[0]    <= '0;
            den_reg[0]  <= den;
            side_reg[0] <= side_in;
        end
    end

    // One quotient bit per stage, MSB first
    generate
        for (j = 1; j <= QW_P; j++) begin : g_stage
            logic [1:0][RMW-1:0] trial;
            logic [1:0]          take;
            for (l = 0; l < 2; l++) begin : g_lane
                assign trial[l] = {rem_reg[j-1][l][RMW-2:0], lo_reg[j-1][l][QW_P-1]};
                assign take[l]  = trial[l] >= RMW'(den_reg[j-1]);
            end

            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        rem_reg[j][i] <= take[i] ? trial[i] - RMW'(den_reg[j-1]) : trial[i];
                        lo_reg[j][i]  <= lo_reg[j-1][i] << 1;
                        q_reg[j][i]   <= {q_reg[j-1][i][QW_P-2:0], take[i]};
                    end
                    ovf_reg[j]  <= ovf_reg[j-1];
                    den_reg[j]  <= den_reg[j-1];
                    side_reg[j] <= side_reg[j-1];
                end
            end
        end
    endgenerate

endmodule

>>> rtl/segment_circle_hit_test.sv
// Top level: configuration registers, geometry pipeline, divider and foot output register.
//
// Segment/circle hit test. Each transfer on the seg channel carries one segment
// (start and end point, Q12.4); each transfer on the res channel carries its result:
// hit flag, foot of the perpendicular from the circle centre (saturated Q12.4) and a
// zero-length flag. Results leave in the order segments arrive, one per segment.
// The circle centre and radius are written over the APB port at byte addresses
// 0x0, 0x4 and 0x8, by the user only while no segment is in flight (the block does
// not enforce this); pready is tied high. Throughput is one segment per cycle while
// res_ready is high. An accepted segment passes 7 geometry stages, 18 divider stages
// (an overflow check, then one quotient bit per stage) and the output register.
// Each stage moves whenever it is empty or the stage after it moves, so bubbles
// close up while res_ready is low and new segments are still taken until the
// pipeline is full; nothing is dropped or repeated across a stall.
// Reset clears every valid bit and sets the centre and radius to zero.
module segment_circle_hit_test
    import sch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    output logic              seg_ready,
    input  seg_t              seg,
    output logic              res_valid,
    input  logic              res_ready,
    output res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic signed [CW-1:0] centre_x_reg, centre_y_reg;
    logic [RW-1:0]        radius_reg;
    cfg_t                 cfg;
    logic                 wr;
    logic [IDX_W-1:0]     idx;

    // Configuration registers
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_x_reg <= '0;
            centre_y_reg <= '0;
            radius_reg   <= '0;
        end
        else if (wr)
        begin
            case (idx)
                REG_CENTRE_X: centre_x_reg <= pwdata[CW-1:0];
                REG_CENTRE_Y: centre_y_reg <= pwdata[CW-1:0];
                REG_RADIUS:   radius_reg   <= pwdata[RW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CENTRE_X: prdata = 32'($unsigned(centre_x_reg));
            REG_CENTRE_Y: prdata = 32'($unsigned(centre_y_reg));
            REG_RADIUS:   prdata = 32'(radius_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.centre_x = centre_x_reg;
    assign cfg.centre_y = centre_y_reg;
    assign cfg.radius   = radius_reg;

    // Geometry pipeline
    logic   fr_valid, fr_ready;
    front_t fr;

    sch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (seg_valid),
        .in_ready  (seg_ready),
        .seg       (seg),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out       (fr)
    );

    // Divider
    logic                 dv_valid, dv_ready;
    logic [1:0][QW-1:0]   dv_q;
    logic [1:0]           dv_ovf;
    logic [$bits(side_t)-1:0] dv_side_bits;
    side_t                dv_side;

    sch_div #(
        .NW   (NNW),
        .DW   (DDW),
        .QW_P (QW),
        .SW   ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .num       ({fr.num_y, fr.num_x}),
        .den       (fr.den),
        .side_in   (fr.side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .quo       (dv_q),
        .ovf       (dv_ovf),
        .side_out  (dv_side_bits)
    );

    assign dv_side = side_t'(dv_side_bits);

    // Foot: start plus signed rounded offset, saturated
    localparam logic signed [QW+1:0] FOOT_MAX = (QW+2)'(2**(CW-1) - 1);
    localparam logic signed [QW+1:0] FOOT_MIN = -FOOT_MAX - (QW+2)'(1);

    logic signed [QW+1:0] fsum [2];
    logic signed [CW-1:0] foot [2];

    always_comb
    begin
        logic [QW:0]          mag;
        logic signed [QW+1:0] off;
        logic                 neg;
        logic signed [CW-1:0] s;
        for (int i = 0; i < 2; i++)
        begin
            neg = (i == 0) ? dv_side.neg_x : dv_side.neg_y;
            s   = (i == 0) ? dv_side.sx : dv_side.sy;
            mag = dv_ovf[i] ? ((QW+1)'(1) << QW) : (QW+1)'(dv_q[i]);
            off = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            fsum[i] = (QW+2)'(s) + off;
            if (dv_side.zl)
            begin
                foot[i] = s;
            end
            else if (fsum[i] > FOOT_MAX)
            begin
                foot[i] = FOOT_MAX[CW-1:0];
            end
            else if (fsum[i] < FOOT_MIN)
            begin
                foot[i] = FOOT_MIN[CW-1:0];
            end
            else
            begin
                foot[i] = fsum[i][CW-1:0];
            end
        end
    end

    // Output register
    logic res_valid_reg;
    res_t res_reg;

    assign dv_ready  = ~res_valid_reg | res_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (dv_ready)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_ready && dv_valid)
        begin
            res_reg.hit         <= dv_side.hit;
            res_reg.foot_x      <= foot[0];
            res_reg.foot_y      <= foot[1];
            res_reg.zero_length <= dv_side.zl;
        end
    end

    // A degenerate segment never reports a hit
    a_zl_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.zero_length |-> !res_reg.hit)
        else $error("zero-length segment reported a hit");

    // A divider result held back by a stalled output is still there next cycle
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid && res_valid_reg && !res_ready |=> dv_valid)
        else $error("divider result lost during output stall");

    // Radius readback never carries bits above the radius width
    a_radius_rd: assert property (@(posedge clk) disable iff (!rst_n)
        idx == REG_RADIUS |-> prdata[31:RW] == '0)
        else $error("radius readback has stray high bits");

endmodule

>>> tb/result_checker.sv
// Result checker: watches both channels and the register port, predicts and compares.
`timescale 1ns / 1ps

module result_checker
    import sch_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    input  logic              seg_ready,
    input  seg_t              seg,
    input  logic              res_valid,
    input  logic              res_ready,
    input  res_t              res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output int                failures,
    output int                pending
);

    typedef logic signed [127:0] big_t;

    // shadow copy of the circle registers
    cfg_t circle;
    res_t awaited_results[$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        failures++;
    endtask

    // one foot coordinate: start + v * dot / L2, rounded half away, saturated
    function automatic logic signed [CW-1:0] foot_coord(input big_t s, input big_t vc,
                                                        input big_t dot, input big_t len2);
        big_t num;
        big_t mag;
        big_t q;
        big_t f;
        num = vc * dot;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + len2) / (2 * len2);
        if (q > (big_t'(1) <<< 40))
            q = big_t'(1) <<< 40;
        f = (num < 0) ? s - q : s + q;
        if (f > 32767)
            f = 32767;
        if (f < -32768)
            f = -32768;
        return f[CW-1:0];
    endfunction

    function automatic res_t circle_hit(input seg_t s, input cfg_t c);
        big_t sx, sy, ex, ey, vx, vy, ax, ay, bx, by, rad;
        big_t r2, len2, cr, dva, dvb, a2, b2;
        logic near_line, between, inside_circle;
        res_t r;
        sx = big_t'(s.start_x);
        sy = big_t'(s.start_y);
        ex = big_t'(s.end_x);
        ey = big_t'(s.end_y);
        rad = big_t'(c.radius);
        vx = ex - sx;
        vy = ey - sy;
        ax = big_t'(c.centre_x) - sx;
        ay = big_t'(c.centre_y) - sy;
        bx = big_t'(c.centre_x) - ex;
        by = big_t'(c.centre_y) - ey;
        r = '0;
        r.foot_x = s.start_x;
        r.foot_y = s.start_y;
        if (vx == 0 && vy == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        r2   = rad * rad;
        len2 = vx * vx + vy * vy;
        cr   = vx * ay - vy * ax;
        dva  = vx * ax + vy * ay;
        dvb  = vx * bx + vy * by;
        a2   = ax * ax + ay * ay;
        b2   = bx * bx + by * by;
        near_line = (cr * cr) <= (r2 * len2);
        between = (dva == 0) || (dvb == 0) || ((dva < 0) != (dvb < 0));
        inside_circle = (a2 < r2) || (b2 < r2);
        r.hit = near_line && (between || inside_circle);
        r.foot_x = foot_coord(sx, vx, dva, len2);
        r.foot_y = foot_coord(sy, vy, dva, len2);
        return r;
    endfunction

    assign pending = awaited_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            circle <= '0;
            failures = 0;
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_CENTRE_X: circle.centre_x <= pwdata[CW-1:0];
                    REG_CENTRE_Y: circle.centre_y <= pwdata[CW-1:0];
                    REG_RADIUS:   circle.radius   <= pwdata[RW-1:0];
                    default: ;
                endcase
            end
            // segment transfer
            if (seg_valid && seg_ready)
                awaited_results.push_back(circle_hit(seg, circle));
            // result transfer
            if (res_valid && res_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("unexpected result at %0t", $realtime);
                    failures++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (res.hit !== want.hit)
                        report_mismatch("hit", 32'(res.hit), 32'(want.hit));
                    if (res.foot_x !== want.foot_x)
                        report_mismatch("foot_x", 32'(res.foot_x), 32'(want.foot_x));
                    if (res.foot_y !== want.foot_y)
                        report_mismatch("foot_y", 32'(res.foot_y), 32'(want.foot_y));
                    if (res.zero_length !== want.zero_length)
                        report_mismatch("zero_length", 32'(res.zero_length),
                                        32'(want.zero_length));
                end
            end
        end
    end

endmodule

>>> tb/testbench.sv
// Testbench top: clock, reset, register writes, segment stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import sch_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              seg_valid;
    logic              seg_ready;
    seg_t              seg;
    logic              res_valid;
    logic              res_ready;
    res_t              res;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                failures;
    int                pending;
    int                hold_requests;
    cfg_t              circle_now;

    segment_circle_hit_test uut (.*);

    result_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .seg_valid(seg_valid), .seg_ready(seg_ready), .seg(seg),
        .res_valid(res_valid), .res_ready(res_ready), .res(res),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .failures(failures), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #8_000_000;
        $display("[segment_circle_hit_test] ERROR");
        $finish;
    end

    // result side: random stalls, occasional long hold-off on request
    initial
    begin
        int gap;
        int served;
        int calm;
        res_ready = 1'b0;
        served = 0;
        calm = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != served)
            begin
                served = hold_requests;
                res_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (calm > 0)
            begin
                calm--;
                res_ready <= 1'b1;
            end
            else if ($urandom_range(0, 19) == 0)
                calm = $urandom_range(20, 80);
            else if ($urandom_range(0, 2) == 0)
            begin
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 3);
                res_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            else
                res_ready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_circle(input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                              input logic [RW-1:0] r);
        reg_write(REG_CENTRE_X, {{(32-CW){cx[CW-1]}}, cx});
        reg_write(REG_CENTRE_Y, {{(32-CW){cy[CW-1]}}, cy});
        reg_write(REG_RADIUS, {{(32-RW){1'b0}}, r});
        circle_now = '{centre_x: cx, centre_y: cy, radius: r};
    endtask

    // offer one segment, then an optional gap
    task automatic send_segment(input seg_t s);
        int gap;
        seg_valid <= 1'b1;
        seg       <= s;
        @(negedge clk);
        while (!seg_ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        gap = 0;
        if ($urandom_range(0, 3) == 0)
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            seg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [CW-1:0] near_centre(input logic [CW-1:0] c, input int spread);
        return c + CW'($urandom_range(0, 2 * spread) - spread);
    endfunction

    function automatic seg_t random_segment();
        seg_t s;
        int spread;
        logic [CW-1:0] corner [4];
        corner = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        spread = 2 * circle_now.radius + 64;
        case ($urandom_range(0, 9))
            0, 1:
                s = {$urandom(), $urandom()};
            2:
            begin
                s.start_x = CW'($urandom());
                s.start_y = CW'($urandom());
                s.end_x = s.start_x;
                s.end_y = s.start_y;
            end
            3:
                s = {corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)],
                     corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)]};
            default:
            begin
                s.start_x = near_centre(circle_now.centre_x, spread);
                s.start_y = near_centre(circle_now.centre_y, spread);
                s.end_x   = near_centre(circle_now.centre_x, spread);
                s.end_y   = near_centre(circle_now.centre_y, spread);
            end
        endcase
        return s;
    endfunction

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        seg_t directed [$];
        int   phase;
        rst_n         = 1'b0;
        seg_valid     = 1'b0;
        seg           = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_requests = 0;
        circle_now    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0: ;
                1: set_circle(16'sd0, 16'sd0, 15'd1600);
                2: set_circle(-16'sd32768, -16'sd32768, 15'h7fff);
                3: set_circle(16'sd32767, 16'sd32767, 15'd0);
                4: set_circle(16'sd32767, -16'sd32768, 15'h7fff);
                5: set_circle(16'sd100, -16'sd50, 15'd1);
                default: set_circle(CW'($urandom()), CW'($urandom()),
                                    RW'($urandom_range(0, 4000)));
            endcase

            // directed cases: zero length, extremes, tangent, endpoint inside, saturation
            if (phase == 1 || phase == 2)
            begin
                directed = '{
                    '{16'sd5, 16'sd5, 16'sd5, 16'sd5},
                    '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
                    '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767},
                    '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767},
                    '{-16'sd3000, 16'sd0, 16'sd3000, 16'sd0},
                    '{-16'sd3000, 16'sd1600, 16'sd3000, 16'sd1600},
                    '{-16'sd3000, 16'sd1601, 16'sd3000, 16'sd1601},
                    '{16'sd10, 16'sd10, 16'sd4000, 16'sd4000},
                    '{16'sd2000, 16'sd0, 16'sd4000, 16'sd0},
                    '{16'sd1000, 16'sd0, 16'sd4000, 16'sd0},
                    '{16'sd32767, 16'sd32767, 16'sd32766, 16'sd32767},
                    '{-16'sd32768, 16'sd32767, -16'sd32767, -16'sd32768},
                    '{16'sd0, 16'sd0, 16'sd1, 16'sd0},
                    '{16'sd1600, 16'sd0, 16'sd1600, 16'sd5000},
                    '{16'sd32767, 16'sd0, -16'sd32768, 16'sd1}
                };
                foreach (directed[i])
                    send_segment(directed[i]);
            end

            // long receiver hold-off while segments keep coming
            if (phase == 3 || phase == 7)
                hold_requests++;

            repeat (160)
                send_segment(random_segment());
            seg_valid <= 1'b0;
            drain();
        end

        if (failures == 0 && pending == 0)
            $display("[segment_circle_hit_test] OK");
        else
            $display("[segment_circle_hit_test] ERROR");
        $finish;
    end

endmodule
